FILE: rtl/core/pctdec_pkg.sv
package pctdec_pkg;

    // Byte values and masks used by the decoder.
    localparam logic [7:0] PERCENT_CHAR = 8'h25;
    localparam logic [7:0] CASE_MASK    = 8'hDF;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

    // Codes for the number of bytes held back awaiting a possible escape.
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    // Output queue sizing: one item can release up to three results.
    localparam int MAX_RESULTS = 3;
    localparam int Q_DEPTH     = 4;
    localparam int Q_IDX_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [15:0] count;
    } result_t;

    // True for 0-9, A-F and a-f.
    function automatic logic hex_digit(input logic [7:0] c);
        logic [7:0] u;
        u = c & CASE_MASK;
        return ((c >= 8'h30) && (c <= 8'h39)) || ((u >= 8'h41) && (u <= 8'h46));
    endfunction

    // Value of a hex digit: its low nibble, plus nine for the letters.
    function automatic logic [3:0] digit_value(input logic [7:0] c);
        return c[6] ? (c[3:0] + 4'd9) : c[3:0];
    endfunction

endpackage

FILE: rtl/core/pctdec_step.sv
module pctdec_step (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  logic [7:0]                     in_byte,
    input  logic                           in_last,
    output pctdec_pkg::result_t [2:0]      res,
    output logic [1:0]                     res_num
);
    import pctdec_pkg::*;

    logic [1:0]  held_count_reg, held_count_next;
    logic [7:0]  held0_reg, held0_next;
    logic [7:0]  held1_reg, held1_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] total_inc;
    logic        is_hex;

    assign is_hex    = hex_digit(in_byte);
    assign total_inc = (total_reg < COUNT_MAX) ? (total_reg + 16'd1) : total_reg;

    always_comb
    begin
        res             = '0;
        res_num         = 2'd0;
        held_count_next = held_count_reg;
        held0_next      = held0_reg;
        held1_next      = held1_reg;
        total_next      = total_reg;

        unique case (held_count_reg)
            HELD_ONE:
            begin
                if (is_hex && !in_last)
                begin
                    held1_next      = in_byte;
                    held_count_next = HELD_TWO;
                end
                else
                begin
                    held_count_next = HELD_NONE;
                    res[res_num]    = '{data: held0_reg, last: 1'b0, count: 16'd0};
                    res_num         = res_num + 2'd1;
                    if ((in_byte == PERCENT_CHAR) && !in_last)
                    begin
                        held0_next      = in_byte;
                        held_count_next = HELD_ONE;
                    end
                    else
                    begin
                        res[res_num] = '{data: in_byte, last: in_last,
                                         count: in_last ? total_reg : 16'd0};
                        res_num      = res_num + 2'd1;
                    end
                end
            end
            HELD_TWO:
            begin
                held_count_next = HELD_NONE;
                if (is_hex)
                begin
                    total_next   = total_inc;
                    res[res_num] = '{data: {digit_value(held1_reg), digit_value(in_byte)},
                                     last: in_last, count: in_last ? total_inc : 16'd0};
                    res_num      = res_num + 2'd1;
                end
                else
                begin
                    res[res_num] = '{data: held0_reg, last: 1'b0, count: 16'd0};
                    res_num      = res_num + 2'd1;
                    res[res_num] = '{data: held1_reg, last: 1'b0, count: 16'd0};
                    res_num      = res_num + 2'd1;
                    if ((in_byte == PERCENT_CHAR) && !in_last)
                    begin
                        held0_next      = in_byte;
                        held_count_next = HELD_ONE;
                    end
                    else
                    begin
                        res[res_num] = '{data: in_byte, last: in_last,
                                         count: in_last ? total_reg : 16'd0};
                        res_num      = res_num + 2'd1;
                    end
                end
            end
            default:
            begin
                held_count_next = HELD_NONE;
                if ((in_byte == PERCENT_CHAR) && !in_last)
                begin
                    held0_next      = in_byte;
                    held_count_next = HELD_ONE;
                end
                else
                begin
                    res[res_num] = '{data: in_byte, last: in_last,
                                     count: in_last ? total_reg : 16'd0};
                    res_num      = res_num + 2'd1;
                end
            end
        endcase

        if (in_last)
        begin
            held_count_next = HELD_NONE;
            total_next      = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= HELD_NONE;
            total_reg      <= 16'd0;
        end
        else if (fire)
        begin
            held_count_reg <= held_count_next;
            total_reg      <= total_next;
        end
    end

    // The held bytes are only read once the held count says they were written.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

endmodule

FILE: rtl/core/percent_escape_decoder_core.sv
// Percent-escape decoder: takes a string one byte per transfer, with in_last on its final
// byte, and replaces each '%' followed by two hex digits (either case) with the byte they
// spell; a '%' that is not followed by two hex digits within the same string passes
// through unchanged. The final output byte of each string carries out_last and, in
// escape_count, the number of escapes replaced in it (saturating at 65535). The block
// sustains one input byte per cycle while in_stall is low: an accepted byte is held in an
// input register, is decoded there, and its results (none, or up to three when held bytes
// are released) enter a four-entry output queue as that register advances. The input
// register advances whenever the queue, counting the entry leaving in that cycle, has room
// for the results of the byte it holds. Every byte either sits in the queue or is held back
// for a possible escape, and while the output side takes one transfer per cycle the two
// together never exceed three, so in_stall only rises when the output side holds off.
module percent_escape_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic [15:0] escape_count
);
    import pctdec_pkg::*;

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       in_accept;
    logic       advance;

    // Results from the decode step.
    result_t [2:0] res;
    logic [1:0]    res_num;

    // Output queue: entry 0 is always the head.
    result_t [Q_DEPTH-1:0] q_reg, q_next;
    logic [Q_CNT_W-1:0]    q_count_reg, q_count_next;
    logic [Q_CNT_W-1:0]    q_base;
    logic                  q_pop;
    logic                  room;

    assign q_pop  = (q_count_reg != '0) && !out_stall;
    assign q_base = q_count_reg - Q_CNT_W'(q_pop);
    assign room   = ((q_base + Q_CNT_W'(res_num)) <= Q_CNT_W'(Q_DEPTH));

    assign advance   = in_valid_reg && room;
    assign in_stall  = in_valid_reg && !room;
    assign in_accept = in_valid && !in_stall;

    assign in_valid_next = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
    end

    // The decode step holds the escape state and updates it as the input register advances.
    pctdec_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (advance),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .res     (res),
        .res_num (res_num)
    );

    // Queue update: shift out the head on a pop, then append the new results behind
    // whatever remains.
    always_comb
    begin
        logic [Q_CNT_W-1:0] slot;
        q_next = q_reg;
        slot   = '0;
        if (q_pop)
        begin
            for (int i = 0; i < Q_DEPTH - 1; i++)
            begin
                q_next[i] = q_reg[i+1];
            end
        end
        if (advance)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                slot = q_base + Q_CNT_W'(i);
                if (2'(i) < res_num)
                begin
                    q_next[slot[Q_IDX_W-1:0]] = res[i];
                end
            end
        end
        q_count_next = q_base + (advance ? Q_CNT_W'(res_num) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_count_reg <= '0;
        end
        else
        begin
            q_count_reg <= q_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign out_valid    = (q_count_reg != '0);
    assign out_byte     = q_reg[0].data;
    assign out_last     = q_reg[0].last;
    assign escape_count = q_reg[0].count;

    // The queue never holds more entries than it has.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("output queue count beyond its depth");

    // The escape count is only carried on the final byte of a string.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_last) |-> (escape_count == 16'd0))
        else $error("escape count on a byte that is not the last");

    // A lone queued entry taken with nothing arriving leaves the queue empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_count_reg == Q_CNT_W'(1) && q_pop && !advance) |=> !out_valid)
        else $error("output still valid after the queue drained");

    // Whenever the input register holds an item and the queue is empty, it advances.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && q_count_reg == '0) |-> !in_stall)
        else $error("input stalled with an empty output queue");

endmodule
